### hw/rtl/cbd_pkg.sv
package cbd_pkg;

	localparam int unsigned LenW = 16;

	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;
	localparam logic [7:0] ChUpA   = 8'h41;
	localparam logic [7:0] ChUpF   = 8'h46;
	localparam logic [3:0] HexTen  = 4'd10;

	typedef struct packed {
		logic [7:0] raw_byte;
		logic       is_last;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_data;
		logic       end_of_body;
	} out_beat_t;

	typedef struct packed {
		logic            in_data;
		logic [LenW-1:0] remaining;
		logic            skip_next;
	} dec_state_t;

	localparam dec_state_t StateReset = '{in_data: 1'b0, remaining: '0, skip_next: 1'b0};

endpackage

### hw/rtl/cbd_stream_if.sv
interface cbd_stream_if #(
	parameter type payload_t = logic [0:0]
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/cbd_step.sv
module cbd_step (
	input  cbd_pkg::dec_state_t cur,
	input  cbd_pkg::in_beat_t   beat,
	output cbd_pkg::dec_state_t nxt,
	output cbd_pkg::out_beat_t  res,
	output logic                has_res
);
	logic       is_dec;
	logic       is_hex;
	logic [3:0] hex_val;
	logic       have;
	cbd_pkg::dec_state_t upd;

	always_comb begin
		is_dec = (beat.raw_byte >= cbd_pkg::ChZero) && (beat.raw_byte <= cbd_pkg::ChNine);
		is_hex = (beat.raw_byte >= cbd_pkg::ChUpA) && (beat.raw_byte <= cbd_pkg::ChUpF);
		if (is_dec) begin
			hex_val = 4'(beat.raw_byte - cbd_pkg::ChZero);
		end else begin
			hex_val = 4'(beat.raw_byte - cbd_pkg::ChUpA) + cbd_pkg::HexTen;
		end
	end

	always_comb begin
		upd  = cur;
		have = 1'b0;
		if (cur.skip_next) begin
			upd.skip_next = 1'b0;
		end else if (cur.in_data) begin
			if (cur.remaining != '0) begin
				have          = 1'b1;
				upd.remaining = cur.remaining - 1'b1;
			end else begin
				upd.skip_next = 1'b1;
				upd.in_data   = 1'b0;
			end
		end else if (is_dec || is_hex) begin
			upd.remaining = {cur.remaining[cbd_pkg::LenW-5:0], hex_val};
		end else if (cur.remaining != '0) begin
			upd.in_data   = 1'b1;
			upd.skip_next = 1'b1;
		end
	end

	always_comb begin
		nxt             = beat.is_last ? cbd_pkg::StateReset : upd;
		res.data_byte   = have ? beat.raw_byte : 8'h00;
		res.has_data    = have;
		res.end_of_body = beat.is_last;
		has_res         = have || beat.is_last;
	end
endmodule

### hw/rtl/chunked_body_decoder.sv
// Chunked body decoder: one raw byte in, at most one payload beat out.
// A beat is held in the input register until its result can enter the output register.
// One byte per cycle unless a result waits on a stalled output; cbd_step is combinational.
// Beats that yield no result retire from the input register without waiting on the output.
// Reset (arst_n low, asynchronous): size mode, length zero, both registers empty.
module chunked_body_decoder (
	input  logic               clk,
	input  logic               arst_n,
	cbd_stream_if.sink         body,
	cbd_stream_if.source       payload
);
	cbd_pkg::in_beat_t   beat_s1;
	logic                valid_s1;
	cbd_pkg::out_beat_t  res_s2;
	logic                valid_s2;
	cbd_pkg::dec_state_t state_q;

	cbd_pkg::dec_state_t state_nxt;
	cbd_pkg::out_beat_t  res_nxt;
	logic                has_res;
	logic                s2_free;
	logic                adv_s1;

	cbd_step u_step (
		.cur     (state_q),
		.beat    (beat_s1),
		.nxt     (state_nxt),
		.res     (res_nxt),
		.has_res (has_res)
	);

	assign s2_free    = !valid_s2 || payload.ready;
	assign adv_s1     = valid_s1 && (!has_res || s2_free);
	assign body.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (body.ready) begin
			valid_s1 <= body.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (body.ready && body.valid) begin
			beat_s1 <= body.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cbd_pkg::StateReset;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= adv_s1 && has_res;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && adv_s1 && has_res) begin
			res_s2 <= res_nxt;
		end
	end

	assign payload.valid = valid_s2;
	assign payload.data  = res_s2;

`ifndef SYNTHESIS
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && beat_s1.is_last |=> state_q == cbd_pkg::StateReset)
		else $error("state not cleared after last byte");

	a_no_empty: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> res_s2.has_data || res_s2.end_of_body)
		else $error("empty result beat");

	a_zero_fill: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !res_s2.has_data |-> res_s2.data_byte == 8'h00)
		else $error("data byte not zero without payload");

	a_skip_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.skip_next && state_q.in_data |-> state_q.remaining != '0)
		else $error("entered data mode with zero length");

	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		!body.ready |-> valid_s1 && has_res && valid_s2 && !payload.ready)
		else $error("input stalled without a blocked result");
`endif
endmodule
